### hw/rtl/kda_pkg.sv
// package with shared types and constants for the key debounce block
package kda_pkg;

    localparam int NUM_KEYS_DEF = 11;

    localparam int RAW_W  = NUM_KEYS_DEF;
    localparam int KEY_W  = 4;
    localparam int DEB_W  = 8;
    localparam int DLY_W  = 10;
    localparam int INT_W  = 8;
    localparam int MASK_W = NUM_KEYS_DEF;
    localparam int CFG_W  = (MASK_W > DLY_W) ? MASK_W : DLY_W;
    localparam int CIDX_W = 2;

    localparam int CHG_W  = 9;
    localparam int AGE_W  = 11;
    localparam int SEND_W = 9;

    localparam logic [DEB_W-1:0]  DEBOUNCE_RST = DEB_W'(40);
    localparam logic [DLY_W-1:0]  DELAY_RST    = DLY_W'(300);
    localparam logic [INT_W-1:0]  INTERVAL_RST = INT_W'(30);
    localparam logic [MASK_W-1:0] MASK_RST     = MASK_W'(15);

    typedef enum logic [CIDX_W-1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_DELAY    = 2'd1,
        REG_INTERVAL = 2'd2,
        REG_MASK     = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [DEB_W-1:0] debounce_ms;
        logic [DLY_W-1:0] initial_delay_ms;
        logic [INT_W-1:0] repeat_interval_ms;
    } t_cfg;

    typedef struct packed {
        logic              stable;
        logic              prev;
        logic [CHG_W-1:0]  since_change;
        logic [AGE_W-1:0]  press_age;
        logic [SEND_W-1:0] since_send;
        logic              sent;
    } t_key_state;

    localparam t_key_state KEY_RST = '{
        stable: 1'b1, prev: 1'b1, since_change: '0,
        press_age: '0, since_send: '0, sent: 1'b0
    };

    typedef struct packed {
        logic             push;
        logic             flush;
        logic [KEY_W-1:0] key;
        logic             rep;
    } t_eb_ctl;

endpackage

### hw/rtl/kda_in_if.sv
// input channel interface carrying one tick of raw key levels
interface kda_in_if
    import kda_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_levels;

    modport source (output valid, output raw_levels, input ready);
    modport sink   (input valid, input raw_levels, output ready);
endinterface

### hw/rtl/kda_out_if.sv
// output channel interface carrying one key emission
interface kda_out_if
    import kda_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key_index;
    logic             is_repeat;
    logic             last_of_tick;

    modport source (output valid, output key_index, output is_repeat, output last_of_tick,
                    input ready);
    modport sink   (input valid, input key_index, input is_repeat, input last_of_tick,
                    output ready);
endinterface

### hw/rtl/kda_key_update.sv
// shared per-key update unit: timers, debounce and emission decision
module kda_key_update
    import kda_pkg::*;
(
    input  t_key_state i_state,
    input  logic       i_raw,
    input  logic       i_rep_key,
    input  t_cfg       i_cfg,
    output t_key_state o_state,
    output logic       o_emit,
    output logic       o_is_repeat
);

    t_key_state s;

    always_comb begin
        s = i_state;
        o_emit = 1'b0;
        o_is_repeat = 1'b0;

        if (s.press_age != {AGE_W{1'b1}}) begin
            s.press_age = s.press_age + AGE_W'(1);
        end
        if (s.since_send != {SEND_W{1'b1}}) begin
            s.since_send = s.since_send + SEND_W'(1);
        end

        if (i_raw != s.prev) begin
            s.prev = i_raw;
            s.since_change = '0;
        end else if (s.since_change != {CHG_W{1'b1}}) begin
            s.since_change = s.since_change + CHG_W'(1);
        end

        if ((s.since_change > CHG_W'(i_cfg.debounce_ms)) && (i_raw != s.stable)) begin
            s.stable = i_raw;
            if (!i_raw) begin
                s.sent = 1'b0;
                s.press_age = '0;
                s.since_send = '0;
            end
        end

        if (!s.stable) begin
            if (!s.sent) begin
                s.sent = 1'b1;
                s.since_send = '0;
                o_emit = 1'b1;
            end else if (i_rep_key
                         && (s.press_age >= AGE_W'(i_cfg.initial_delay_ms))
                         && (s.since_send >= SEND_W'(i_cfg.repeat_interval_ms))) begin
                s.since_send = '0;
                o_emit = 1'b1;
                o_is_repeat = 1'b1;
            end
        end

        o_state = s;
    end

endmodule

### hw/rtl/kda_emit_buf.sv
// one-deep holding stage and output register that marks the last emission of a tick
module kda_emit_buf
    import kda_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_eb_ctl          i_ctl,
    output logic             o_ok,
    kda_out_if.source        o_out
);

    logic             r_pend_valid;
    logic [KEY_W-1:0] r_pend_key;
    logic             r_pend_rep;
    logic             r_out_valid;
    logic [KEY_W-1:0] r_out_key;
    logic             r_out_rep;
    logic             r_out_last;
    logic             out_free;
    logic             move;

    assign out_free = !r_out_valid || o_out.ready;
    assign o_ok     = !r_pend_valid || out_free;
    assign move     = o_ok && (i_ctl.push || i_ctl.flush) && r_pend_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end
            if (o_ok && i_ctl.push) begin
                r_pend_valid <= 1'b1;
            end else if (o_ok && i_ctl.flush) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_key  <= r_pend_key;
            r_out_rep  <= r_pend_rep;
            r_out_last <= i_ctl.flush;
        end
        if (o_ok && i_ctl.push) begin
            r_pend_key <= i_ctl.key;
            r_pend_rep <= i_ctl.rep;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.key_index    = r_out_key;
    assign o_out.is_repeat    = r_out_rep;
    assign o_out.last_of_tick = r_out_last;

endmodule

### hw/rtl/key_debounce_autorepeat_top.sv
// top level of the key debounce and auto-repeat block
//
// i_in carries one transaction per millisecond tick: the raw active-low
// levels of all keys. o_out carries one transaction per key emission, keys
// in ascending order, with last_of_tick set on the final one of a tick.
// A tick with no emission produces no output transaction.
// After a tick is accepted the sequencer walks the keys one per cycle
// through a single shared update unit, pausing while an emission cannot
// enter the holding stage, then flushes the held emission in ST_FLUSH and
// returns to ST_IDLE, where ready rises again for the next tick. The first
// emission of a tick reaches the output register once the next emission or
// the flush moves it out of the holding stage.
// One emission is held back so last_of_tick can be known; when the output
// receiver stalls, the scan pauses on the key that needs the holding stage.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data; the user
// must write it only while idle, as the block does not enforce this.
// Synchronous reset returns the registers to their defaults and all keys
// to released with cleared timers; no clearing pass is needed.
module key_debounce_autorepeat_top
    import kda_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    kda_in_if.sink            i_in,
    kda_out_if.source         o_out,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    localparam int NUM_KEYS = NUM_KEYS_DEF;
    localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_KEYS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    t_cfg              r_cfg;
    logic [MASK_W-1:0] r_mask;

    t_state            r_state;
    logic [IDX_W-1:0]  r_idx;
    logic [RAW_W-1:0]  r_raw;
    t_key_state        r_keys [NUM_KEYS];

    logic [NUM_KEYS-1:0] raw_vec;
    logic [NUM_KEYS-1:0] mask_vec;
    t_key_state          cur_state;
    t_key_state          upd_state;
    logic                emit;
    logic                emit_rep;
    logic                eb_ok;
    t_eb_ctl             eb_ctl;
    logic                step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms        <= DEBOUNCE_RST;
            r_cfg.initial_delay_ms   <= DELAY_RST;
            r_cfg.repeat_interval_ms <= INTERVAL_RST;
            r_mask                   <= MASK_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_DEBOUNCE: r_cfg.debounce_ms        <= i_cfg_data[DEB_W-1:0];
                REG_DELAY:    r_cfg.initial_delay_ms   <= i_cfg_data[DLY_W-1:0];
                REG_INTERVAL: r_cfg.repeat_interval_ms <= i_cfg_data[INT_W-1:0];
                REG_MASK:     r_mask                   <= i_cfg_data[MASK_W-1:0];
                default:      r_mask                   <= r_mask;
            endcase
        end
    end

    assign raw_vec   = NUM_KEYS'(r_raw);
    assign mask_vec  = NUM_KEYS'(r_mask);
    assign cur_state = r_keys[r_idx];

    kda_key_update u_update (
        .i_state     (cur_state),
        .i_raw       (raw_vec[r_idx]),
        .i_rep_key   (mask_vec[r_idx]),
        .i_cfg       (r_cfg),
        .o_state     (upd_state),
        .o_emit      (emit),
        .o_is_repeat (emit_rep)
    );

    // a key commits unless its emission cannot enter the holding stage
    assign step = (r_state == ST_SCAN) && (!emit || eb_ok);

    always_comb begin
        eb_ctl.push  = (r_state == ST_SCAN) && emit;
        eb_ctl.flush = (r_state == ST_FLUSH);
        eb_ctl.key   = KEY_W'(r_idx);
        eb_ctl.rep   = emit_rep;
    end

    kda_emit_buf u_emit_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (eb_ctl),
        .o_ok    (eb_ok),
        .o_out   (o_out)
    );

    assign i_in.ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_keys[k] <= KEY_RST;
            end
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_raw   <= i_in.raw_levels;
                        r_idx   <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (step) begin
                        r_keys[r_idx] <= upd_state;
                        if (r_idx == LAST_IDX) begin
                            r_state <= ST_FLUSH;
                        end else begin
                            r_idx <= r_idx + IDX_W'(1);
                        end
                    end
                end
                ST_FLUSH: begin
                    if (eb_ok) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

### tb/tb.sv
// self-checking testbench for the key debounce and auto-repeat block
module tb;
    import kda_pkg::*;

    localparam int NK          = NUM_KEYS_DEF;
    localparam int DRAIN_WAIT  = 20;
    localparam int STALL_LIMIT = 4000;
    localparam int RAND_TICKS  = 18;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             rep;
        logic             last;
    } t_key_emission;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CIDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]  i_cfg_data;

    kda_in_if  in_if ();
    kda_out_if out_if ();

    key_debounce_autorepeat_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // expected register contents and per-key debounce state
    logic [DEB_W-1:0]  exp_debounce;
    logic [DLY_W-1:0]  exp_delay;
    logic [INT_W-1:0]  exp_interval;
    logic [MASK_W-1:0] exp_mask;
    logic [NK-1:0]     key_stable;
    logic [NK-1:0]     key_prev;
    logic [NK-1:0]     key_sent;
    logic [CHG_W-1:0]  key_since_chg  [NK];
    logic [AGE_W-1:0]  key_age        [NK];
    logic [SEND_W-1:0] key_since_send [NK];

    t_key_emission pending_emissions [$];

    logic [RAW_W-1:0] cur_raw;
    int src_idle_pct;
    int snk_idle_pct;
    int err_cnt;
    int tick_cnt;
    int emission_cnt;
    int cfg_cnt;
    int stall_cnt;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void predict_emissions(input logic [RAW_W-1:0] raw);
        logic [NK-1:0] emit_en;
        logic [NK-1:0] emit_rep;
        int            last_k;
        t_key_emission em;
        emit_en  = '0;
        emit_rep = '0;
        last_k   = -1;
        for (int k = 0; k < NK; k++) begin
            if (key_age[k] != '1) key_age[k] = key_age[k] + 1'b1;
            if (key_since_send[k] != '1) key_since_send[k] = key_since_send[k] + 1'b1;
            if (raw[k] != key_prev[k]) begin
                key_prev[k]      = raw[k];
                key_since_chg[k] = '0;
            end else if (key_since_chg[k] != '1) begin
                key_since_chg[k] = key_since_chg[k] + 1'b1;
            end
            if (key_since_chg[k] > exp_debounce && raw[k] != key_stable[k]) begin
                key_stable[k] = raw[k];
                if (!raw[k]) begin
                    key_sent[k]       = 1'b0;
                    key_age[k]        = '0;
                    key_since_send[k] = '0;
                end
            end
            if (!key_stable[k]) begin
                if (!key_sent[k]) begin
                    key_sent[k]       = 1'b1;
                    key_since_send[k] = '0;
                    emit_en[k]        = 1'b1;
                end else if (exp_mask[k] && key_age[k] >= exp_delay &&
                             key_since_send[k] >= exp_interval) begin
                    key_since_send[k] = '0;
                    emit_en[k]        = 1'b1;
                    emit_rep[k]       = 1'b1;
                end
            end
            if (emit_en[k]) last_k = k;
        end
        for (int k = 0; k < NK; k++) begin
            if (emit_en[k]) begin
                em.key  = KEY_W'(k);
                em.rep  = emit_rep[k];
                em.last = (k == last_k);
                pending_emissions.push_back(em);
            end
        end
    endfunction

    task automatic report_mismatch(input string field, input int want, input int got);
        $display("mismatch on %s: expected %0d, got %0d (after tick %0d)",
                 field, want, got, tick_cnt);
        err_cnt++;
    endtask

    // output check first, then prediction of the tick accepted at the same edge
    always @(posedge i_clk) begin
        t_key_emission want;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (pending_emissions.size() == 0) begin
                    report_mismatch("unexpected emission key", -1, out_if.key_index);
                end else begin
                    want = pending_emissions.pop_front();
                    emission_cnt++;
                    if (out_if.key_index !== want.key)
                        report_mismatch("key_index", want.key, out_if.key_index);
                    if (out_if.is_repeat !== want.rep)
                        report_mismatch("is_repeat", want.rep, out_if.is_repeat);
                    if (out_if.last_of_tick !== want.last)
                        report_mismatch("last_of_tick", want.last, out_if.last_of_tick);
                end
            end
            if (in_if.valid && in_if.ready) begin
                tick_cnt++;
                predict_emissions(in_if.raw_levels);
            end
        end
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || i_cfg_we)
            stall_cnt = 0;
        else
            stall_cnt++;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic send_tick(input logic [RAW_W-1:0] raw);
        if ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.raw_levels <= raw;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic hold_keys(input logic [RAW_W-1:0] raw, input int n);
        for (int i = 0; i < n; i++) send_tick(raw);
    endtask

    // ticks with no emission may still be scanning, so wait out a full tick
    task automatic drain_block();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_emissions.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_DEBOUNCE: exp_debounce = data[DEB_W-1:0];
            REG_DELAY:    exp_delay    = data[DLY_W-1:0];
            REG_INTERVAL: exp_interval = data[INT_W-1:0];
            REG_MASK:     exp_mask     = data[MASK_W-1:0];
            default: ;
        endcase
        cfg_cnt++;
    endtask

    // keys 0 (repeat) and 5 (one-shot) must settle only after the default debounce
    task automatic test_reset_defaults();
        hold_keys(11'h7DE, 42);
        hold_keys(11'h7FF, 2);
    endtask

    // upper data bits are dropped, leaving zero debounce, delay and interval
    task automatic test_zero_settings();
        drain_block();
        write_reg(REG_DEBOUNCE, 11'h700);
        write_reg(REG_DELAY, 11'h400);
        write_reg(REG_INTERVAL, 11'h100);
        write_reg(REG_MASK, 11'h7FF);
        hold_keys(11'h000, 3);
        hold_keys(11'h7FF, 2);
        hold_keys(11'h000, 2);
    endtask

    // a one-tick bounce is filtered, then mixed one-shot and repeat keys held
    task automatic test_oneshot_and_repeat();
        drain_block();
        write_reg(REG_DEBOUNCE, 11'd1);
        write_reg(REG_DELAY, 11'd2);
        write_reg(REG_INTERVAL, 11'd3);
        write_reg(REG_MASK, 11'h2AA);
        hold_keys(11'h7F7, 1);
        hold_keys(11'h7FF, 2);
        hold_keys(11'h000, 10);
        hold_keys(11'h7FF, 3);
    endtask

    task automatic test_max_settings();
        drain_block();
        write_reg(REG_DEBOUNCE, 11'h0FF);
        write_reg(REG_DELAY, 11'h3FF);
        write_reg(REG_INTERVAL, 11'h0FF);
        write_reg(REG_MASK, 11'h000);
        hold_keys(11'h000, 3);
        hold_keys(11'h7FF, 1);
    endtask

    // key levels toggle now and then so holds outlast the short timings
    task automatic test_random_traffic(input int src_pct, input int snk_pct);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int seg = 0; seg < 2; seg++) begin
            drain_block();
            write_reg(REG_DEBOUNCE, {3'($urandom_range(7)), 8'($urandom_range(4))});
            write_reg(REG_DELAY, {1'($urandom), 10'($urandom_range(12))});
            write_reg(REG_INTERVAL, {3'($urandom_range(7)), 8'($urandom_range(6))});
            write_reg(REG_MASK, 11'($urandom));
            for (int i = 0; i < RAND_TICKS; i++) begin
                if ($urandom_range(99) < 8) begin
                    cur_raw = RAW_W'($urandom);
                end else begin
                    for (int k = 0; k < NK; k++)
                        if ($urandom_range(7) == 0) cur_raw[k] = ~cur_raw[k];
                end
                send_tick(cur_raw);
            end
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = REG_DEBOUNCE;
        i_cfg_data       = '0;
        in_if.valid      = 1'b0;
        in_if.raw_levels = '1;
        out_if.ready     = 1'b0;
        src_idle_pct     = 13;
        snk_idle_pct     = 52;
        err_cnt          = 0;
        tick_cnt         = 0;
        emission_cnt     = 0;
        cfg_cnt          = 0;
        stall_cnt        = 0;
        cur_raw          = '1;
        exp_debounce     = DEBOUNCE_RST;
        exp_delay        = DELAY_RST;
        exp_interval     = INTERVAL_RST;
        exp_mask         = MASK_RST;
        key_stable       = '1;
        key_prev         = '1;
        key_sent         = '0;
        for (int k = 0; k < NK; k++) begin
            key_since_chg[k]  = '0;
            key_age[k]        = '0;
            key_since_send[k] = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_zero_settings();
        test_oneshot_and_repeat();
        test_max_settings();
        test_random_traffic(13, 52);
        test_random_traffic(52, 13);
        test_random_traffic(0, 0);
        drain_block();

        $display("run: %0d ticks sent, %0d emissions checked, %0d register writes",
                 tick_cnt, emission_cnt, cfg_cnt);
        $display("timings from zero to full scale, one-shot and repeat keys, with stalls");
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
